// ----- hdl/es2dt_pkg.sv -----
// ----------------------------------------------------------------------------
// es2dt_pkg: shared types and constants for the epoch seconds converter
// Holds the calendar constants, the subtractor result type and the
// month and year length helpers.
// ----------------------------------------------------------------------------
package es2dt_pkg;

  localparam int unsigned SubWidth = 18;

  // Result of the shared subtractor: difference and borrow out.
  typedef struct packed {
    logic [SubWidth-1:0] diff;
    logic                borrow;
  } sub_res_t;

  localparam logic [SubWidth-1:0] SecsPerDay  = 18'd86400;
  localparam logic [SubWidth-1:0] SecsPerHour = 18'd3600;
  localparam logic [SubWidth-1:0] SecsPerMin  = 18'd60;

  // Last step index of each restoring division.
  localparam logic [4:0] DayDivLast  = 5'd31;
  localparam logic [4:0] HourDivLast = 5'd16;
  localparam logic [4:0] MinDivLast  = 5'd11;

  localparam logic [10:0] EpochYear  = 11'd1904;
  // 1904 mod 100 and 1904 mod 400.
  localparam logic [6:0]  Mod100Init = 7'd4;
  localparam logic [8:0]  Mod400Init = 9'd304;
  localparam logic [6:0]  Mod100Last = 7'd99;
  localparam logic [8:0]  Mod400Last = 9'd399;

  localparam logic [3:0]  January  = 4'd1;
  localparam logic [3:0]  February = 4'd2;
  localparam logic [3:0]  December = 4'd12;

  function automatic logic [8:0] year_len(input logic leap);
    return leap ? 9'd366 : 9'd365;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- hdl/epoch_seconds_to_date_time_unit.sv -----
// ----------------------------------------------------------------------------
// epoch_seconds_to_date_time_unit: 1904-epoch seconds to calendar date
// One word is in work at a time: a new word is taken only in StIdle. The
// single shared subtractor does all the arithmetic: 32 + 17 + 12 division
// steps, then one step per year and one per month walked. A finished word
// waits in StFinish while the previous result is still stalled.
// Reset clears the sequencer and the output valid; no word is held.
// ----------------------------------------------------------------------------
module epoch_seconds_to_date_time_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] elapsed_seconds_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [10:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_o,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o
);

  typedef enum logic [2:0] {
    StIdle,
    StDivDay,
    StDivHour,
    StDivMin,
    StYear,
    StMonth,
    StFinish
  } state_e;

  state_e      state_q;
  logic [31:0] num_q;
  logic [17:0] rem_q;
  logic [4:0]  step_q;
  logic [15:0] days_q;
  logic [4:0]  hour_q;
  logic [5:0]  minute_q;
  logic [5:0]  second_q;
  logic [10:0] year_q;
  logic [6:0]  mod100_q;
  logic [8:0]  mod400_q;
  logic [3:0]  month_q;

  logic        out_valid_q;
  logic [10:0] res_year_q;
  logic [3:0]  res_month_q;
  logic [4:0]  res_day_q;
  logic [4:0]  res_hour_q;
  logic [5:0]  res_minute_q;
  logic [5:0]  res_second_q;

  logic [17:0]         cand;
  logic [17:0]         sub_a;
  logic [17:0]         sub_b;
  es2dt_pkg::sub_res_t sub_res;
  logic                q_bit;
  logic [17:0]         rem_nx;
  logic [31:0]         num_nx;
  logic                leap;
  logic                walk_gt;
  logic                step_last;

  // Gregorian rule, with the year's residues kept as running counters.
  assign leap = (year_q[1:0] == 2'd0) && !((mod100_q == 7'd0) && (mod400_q != 9'd0));

  always_comb begin
    cand  = {rem_q[16:0], num_q[31]};
    sub_a = cand;
    sub_b = es2dt_pkg::SecsPerDay;
    case (state_q)
      StDivHour: sub_b = es2dt_pkg::SecsPerHour;
      StDivMin:  sub_b = es2dt_pkg::SecsPerMin;
      StYear: begin
        sub_a = {2'b00, days_q};
        sub_b = {9'd0, es2dt_pkg::year_len(leap)};
      end
      StMonth: begin
        sub_a = {2'b00, days_q};
        sub_b = {13'd0, es2dt_pkg::month_len(month_q, leap)};
      end
      default: sub_b = es2dt_pkg::SecsPerDay;
    endcase
  end

  es2dt_sub u_sub (
    .a_i   (sub_a),
    .b_i   (sub_b),
    .res_o (sub_res)
  );

  assign q_bit   = !sub_res.borrow;
  assign rem_nx  = q_bit ? sub_res.diff : cand;
  assign num_nx  = {num_q[30:0], q_bit};
  assign walk_gt = !sub_res.borrow && (sub_res.diff != 18'd0);

  always_comb begin
    case (state_q)
      StDivDay:  step_last = (step_q == es2dt_pkg::DayDivLast);
      StDivHour: step_last = (step_q == es2dt_pkg::HourDivLast);
      StDivMin:  step_last = (step_q == es2dt_pkg::MinDivLast);
      default:   step_last = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      num_q        <= '0;
      rem_q        <= '0;
      step_q       <= '0;
      days_q       <= '0;
      hour_q       <= '0;
      minute_q     <= '0;
      second_q     <= '0;
      year_q       <= es2dt_pkg::EpochYear;
      mod100_q     <= es2dt_pkg::Mod100Init;
      mod400_q     <= es2dt_pkg::Mod400Init;
      month_q      <= es2dt_pkg::January;
      out_valid_q  <= 1'b0;
      res_year_q   <= '0;
      res_month_q  <= '0;
      res_day_q    <= '0;
      res_hour_q   <= '0;
      res_minute_q <= '0;
      res_second_q <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != StFinish)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            num_q   <= elapsed_seconds_i;
            rem_q   <= '0;
            step_q  <= '0;
            state_q <= StDivDay;
          end
        end
        StDivDay, StDivHour, StDivMin: begin
          num_q  <= num_nx;
          rem_q  <= rem_nx;
          step_q <= step_last ? 5'd0 : step_q + 5'd1;
          if (step_last) begin
            rem_q <= '0;
            case (state_q)
              StDivDay: begin
                // Day count is one-based, so the first day of 1904 is day 1.
                days_q  <= num_nx[15:0] + 16'd1;
                num_q   <= {rem_nx[16:0], 15'd0};
                state_q <= StDivHour;
              end
              StDivHour: begin
                hour_q  <= num_nx[4:0];
                num_q   <= {rem_nx[11:0], 20'd0};
                state_q <= StDivMin;
              end
              default: begin
                minute_q <= num_nx[5:0];
                second_q <= rem_nx[5:0];
                year_q   <= es2dt_pkg::EpochYear;
                mod100_q <= es2dt_pkg::Mod100Init;
                mod400_q <= es2dt_pkg::Mod400Init;
                state_q  <= StYear;
              end
            endcase
          end
        end
        StYear: begin
          if (walk_gt) begin
            days_q   <= sub_res.diff[15:0];
            year_q   <= year_q + 11'd1;
            mod100_q <= (mod100_q == es2dt_pkg::Mod100Last) ? 7'd0 : mod100_q + 7'd1;
            mod400_q <= (mod400_q == es2dt_pkg::Mod400Last) ? 9'd0 : mod400_q + 9'd1;
          end else begin
            month_q <= es2dt_pkg::January;
            state_q <= StMonth;
          end
        end
        StMonth: begin
          if (walk_gt && (month_q != es2dt_pkg::December)) begin
            days_q  <= sub_res.diff[15:0];
            month_q <= month_q + 4'd1;
          end else begin
            state_q <= StFinish;
          end
        end
        StFinish: begin
          // The output register frees as the waiting word is taken.
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            res_year_q   <= year_q;
            res_month_q  <= month_q;
            res_day_q    <= days_q[4:0];
            res_hour_q   <= hour_q;
            res_minute_q <= minute_q;
            res_second_q <= second_q;
            state_q      <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign year_o      = res_year_q;
  assign month_o     = res_month_q;
  assign day_o       = res_day_q;
  assign hour_o      = res_hour_q;
  assign minute_o    = res_minute_q;
  assign second_o    = res_second_q;

endmodule

// ----- hdl/es2dt_sub.sv -----
// ----------------------------------------------------------------------------
// es2dt_sub: shared subtract and compare unit
// One 18-bit subtractor with borrow out, used by every division step and
// by the year and month walks.
// ----------------------------------------------------------------------------
module es2dt_sub (
  input  logic [es2dt_pkg::SubWidth-1:0] a_i,
  input  logic [es2dt_pkg::SubWidth-1:0] b_i,
  output es2dt_pkg::sub_res_t            res_o
);

  logic [es2dt_pkg::SubWidth:0] wide;

  assign wide         = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.diff   = wide[es2dt_pkg::SubWidth-1:0];
  assign res_o.borrow = wide[es2dt_pkg::SubWidth];

endmodule
